/* rtl/core/bpr_pkg.sv */
// Package with shared types and constants of the button press recognizer.
package bpr_pkg;

  localparam int BUTTONS_DEF = 7;
  localparam int MASK_W      = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int TIME_W      = 32;
  localparam int STEPS_W     = 6;
  localparam int RATE_W      = 8;
  localparam int MSCFG_W     = 16;
  localparam int DIVN_W      = 40;
  localparam int DIVD_W      = 16;
  localparam int DIVC_W      = 6;

  localparam logic [9:0] MS_PER_S = 10'd1000;

  typedef enum logic [1:0] {
    CMD_EDGE   = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_FORGET = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_SHORT  = 2'd0,
    KIND_LONG   = 2'd1,
    KIND_REPEAT = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AUTO_REPEAT_MASK = 3'd0,
    REG_LONG_PRESS_MASK  = 3'd1,
    REG_LONG_PRESS_MS    = 3'd2,
    REG_REPEAT_DELAY_MS  = 3'd3,
    REG_REPEAT_RAMP_MS   = 3'd4,
    REG_REPEAT_SLOW_RATE = 3'd5,
    REG_REPEAT_FAST_RATE = 3'd6,
    REG_REPEAT_MAX_STEPS = 3'd7
  } reg_idx_t;

  localparam logic [MSCFG_W-1:0] RST_LONG_PRESS_MS   = 16'd500;
  localparam logic [MSCFG_W-1:0] RST_REPEAT_DELAY_MS = 16'd400;
  localparam logic [MSCFG_W-1:0] RST_REPEAT_RAMP_MS  = 16'd1000;
  localparam logic [RATE_W-1:0]  RST_SLOW_RATE       = 8'd5;
  localparam logic [RATE_W-1:0]  RST_FAST_RATE       = 8'd30;
  localparam logic [STEPS_W-1:0] RST_MAX_STEPS       = 6'd4;

  typedef enum logic [11:0] {
    ST_IDLE    = 12'b000000000001,
    ST_DISP    = 12'b000000000010,
    ST_EDGE    = 12'b000000000100,
    ST_BTN     = 12'b000000001000,
    ST_RATE    = 12'b000000010000,
    ST_RATE_OK = 12'b000000100000,
    ST_STEPS   = 12'b000001000000,
    ST_ANCH    = 12'b000010000000,
    ST_DIV     = 12'b000100000000,
    ST_ADV     = 12'b001000000000,
    ST_NEXT    = 12'b010000000000,
    ST_FIN     = 12'b100000000000
  } state_t;

endpackage

/* rtl/core/bpr_if.sv */
// Channel interfaces for button input items and event results.
interface bpr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [2:0]  button;
  logic        key_down;
  logic [31:0] time_ms;

  modport source (output valid, command, button, key_down, time_ms, input ready);
  modport sink (input valid, command, button, key_down, time_ms, output ready);
endinterface

interface bpr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_button;
  logic [1:0]  event_kind;
  logic [5:0]  repeat_steps;
  logic [31:0] event_time;
  logic        last;

  modport source (output valid, event_button, event_kind, repeat_steps, event_time, last,
                  input ready);
  modport sink (input valid, event_button, event_kind, repeat_steps, event_time, last,
                output ready);
endinterface

/* rtl/core/button_press_recognizer.sv */
// Top level of the button press recognizer with a bit-serial shared divider.
//
// Channel   Dir  Handshake        Content
// in_chan   in   valid/ready      command, button, key_down, time_ms
// out_chan  out  valid/ready      event_button, event_kind, repeat_steps, event_time, last
// cfg_*     in   write enable     register index and data, no read-back
//
// A forget or an ignored edge returns to idle from the dispatch state; an edge goes on to the
// edge state. A tick walks the buttons one by one, and a repeating button also uses the 40-bit
// serial divider that is shared by the rate ramp, the step count and the anchor advance.
// Reset is synchronous and clears all control state and the per-button flags.
// A full output register stalls the walk until its transaction completes.
module button_press_recognizer #(
  parameter int BUTTONS = bpr_pkg::BUTTONS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  bpr_in_if.sink                           in_chan,
  bpr_out_if.source                        out_chan,
  input  logic                             cfg_we,
  input  logic [bpr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bpr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int USABLE = (BUTTONS < 7) ? BUTTONS : 7;
  localparam int IW = (USABLE > 1) ? $clog2(USABLE) : 1;
  localparam logic [2:0] LAST_BTN = 3'(USABLE - 1);
  localparam logic [2:0] USABLE_C = 3'(USABLE);

  bpr_pkg::state_t state_r, ret_r;

  logic [6:0]  arm_r, lpm_r;
  logic [15:0] lpms_r, delay_r, ramp_r;
  logic [7:0]  slow_r, fast_r;
  logic [5:0]  maxst_r;

  logic        is_down_r   [USABLE];
  logic        hold_cons_r [USABLE];
  logic        has_rep_r   [USABLE];
  logic        fired_r     [USABLE];
  logic        latched_r   [USABLE];
  logic [31:0] pst_r       [USABLE];
  logic [31:0] anchor_r    [USABLE];

  logic [1:0]  cmd_r;
  logic [2:0]  btn_r;
  logic        down_r;
  logic [31:0] ms_r;
  logic [2:0]  cnt_r;
  logic        up_r;
  logic [7:0]  rate_r;
  logic [5:0]  steps_r;

  logic [39:0] div_q_r;
  logic [15:0] div_rem_r;
  logic [15:0] div_d_r;
  logic [5:0]  div_cnt_r;

  logic [2:0]  ev_btn_r;
  logic [1:0]  ev_kind_r;
  logic [5:0]  ev_steps_r;
  logic [31:0] ev_time_r;

  logic        pend_v_r;
  logic [2:0]  pend_btn_r;
  logic [1:0]  pend_kind_r;
  logic [5:0]  pend_steps_r;
  logic [31:0] pend_time_r;

  logic        out_v_r;
  logic [2:0]  out_btn_r;
  logic [1:0]  out_kind_r;
  logic [5:0]  out_steps_r;
  logic [31:0] out_time_r;
  logic        out_last_r;

  logic [IW-1:0] bi, ci;
  logic [31:0]   held_b, held_c, t_c, anc_new, elapsed;
  logic [16:0]   trial;
  logic          out_free;
  logic          out_load;
  logic [5:0]    cap;
  logic [7:0]    diff;

  assign bi       = btn_r[IW-1:0];
  assign ci       = cnt_r[IW-1:0];
  assign held_b   = ms_r - pst_r[bi];
  assign held_c   = ms_r - pst_r[ci];
  assign t_c      = held_c - {16'b0, delay_r};
  assign anc_new  = has_rep_r[ci] ? anchor_r[ci] : pst_r[ci] + {16'b0, delay_r};
  assign elapsed  = ms_r - anc_new;
  assign trial    = {div_rem_r, div_q_r[39]};
  assign out_free = !out_v_r || out_chan.ready;
  assign out_load = pend_v_r && out_free &&
                    (state_r == bpr_pkg::ST_ADV || state_r == bpr_pkg::ST_FIN);
  assign cap      = (maxst_r == 6'd0) ? 6'd1 : maxst_r;
  assign diff     = (fast_r >= slow_r) ? fast_r - slow_r : slow_r - fast_r;

  assign in_chan.ready         = (state_r == bpr_pkg::ST_IDLE);
  assign out_chan.valid        = out_v_r;
  assign out_chan.event_button = out_btn_r;
  assign out_chan.event_kind   = out_kind_r;
  assign out_chan.repeat_steps = out_steps_r;
  assign out_chan.event_time   = out_time_r;
  assign out_chan.last         = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_r   <= '0;
      lpm_r   <= '0;
      lpms_r  <= bpr_pkg::RST_LONG_PRESS_MS;
      delay_r <= bpr_pkg::RST_REPEAT_DELAY_MS;
      ramp_r  <= bpr_pkg::RST_REPEAT_RAMP_MS;
      slow_r  <= bpr_pkg::RST_SLOW_RATE;
      fast_r  <= bpr_pkg::RST_FAST_RATE;
      maxst_r <= bpr_pkg::RST_MAX_STEPS;
    end else if (cfg_we) begin
      case (bpr_pkg::reg_idx_t'(cfg_index))
        bpr_pkg::REG_AUTO_REPEAT_MASK: begin
          arm_r <= cfg_data[6:0];
          lpm_r <= lpm_r & ~cfg_data[6:0];
        end
        bpr_pkg::REG_LONG_PRESS_MASK:  lpm_r   <= cfg_data[6:0] & ~arm_r;
        bpr_pkg::REG_LONG_PRESS_MS:    lpms_r  <= cfg_data;
        bpr_pkg::REG_REPEAT_DELAY_MS:  delay_r <= cfg_data;
        bpr_pkg::REG_REPEAT_RAMP_MS:   ramp_r  <= cfg_data;
        bpr_pkg::REG_REPEAT_SLOW_RATE: slow_r  <= cfg_data[7:0];
        bpr_pkg::REG_REPEAT_FAST_RATE: fast_r  <= cfg_data[7:0];
        bpr_pkg::REG_REPEAT_MAX_STEPS: maxst_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bpr_pkg::ST_IDLE;
      ret_r    <= bpr_pkg::ST_IDLE;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      for (int i = 0; i < USABLE; i++) begin
        is_down_r[i]   <= 1'b0;
        hold_cons_r[i] <= 1'b0;
        has_rep_r[i]   <= 1'b0;
        fired_r[i]     <= 1'b0;
        latched_r[i]   <= 1'b0;
      end
    end else begin
      if (out_v_r && out_chan.ready && !out_load) begin
        out_v_r <= 1'b0;
      end
      case (state_r)
        bpr_pkg::ST_IDLE: begin
          if (in_chan.valid) begin
            cmd_r   <= in_chan.command;
            btn_r   <= in_chan.button;
            down_r  <= in_chan.key_down;
            ms_r    <= in_chan.time_ms;
            state_r <= bpr_pkg::ST_DISP;
          end
        end
        bpr_pkg::ST_DISP: begin
          cnt_r   <= '0;
          state_r <= bpr_pkg::ST_IDLE;
          case (bpr_pkg::cmd_t'(cmd_r))
            bpr_pkg::CMD_FORGET: begin
              for (int i = 0; i < USABLE; i++) begin
                is_down_r[i]   <= 1'b0;
                hold_cons_r[i] <= 1'b0;
                has_rep_r[i]   <= 1'b0;
                fired_r[i]     <= 1'b0;
                latched_r[i]   <= 1'b0;
              end
            end
            bpr_pkg::CMD_EDGE: begin
              if (btn_r < USABLE_C) begin
                state_r <= bpr_pkg::ST_EDGE;
              end
            end
            bpr_pkg::CMD_TICK: state_r <= bpr_pkg::ST_BTN;
            default: ;
          endcase
        end
        bpr_pkg::ST_EDGE: begin
          ev_btn_r   <= btn_r;
          ev_steps_r <= 6'd1;
          ev_time_r  <= ms_r;
          state_r    <= bpr_pkg::ST_FIN;
          if (down_r) begin
            if (!is_down_r[bi]) begin
              is_down_r[bi]   <= 1'b1;
              hold_cons_r[bi] <= 1'b0;
              has_rep_r[bi]   <= 1'b0;
              anchor_r[bi]    <= ms_r;
              pst_r[bi]       <= ms_r;
              latched_r[bi]   <= arm_r[btn_r];
              fired_r[bi]     <= !lpm_r[btn_r];
              if (!lpm_r[btn_r]) begin
                ev_kind_r <= bpr_pkg::KIND_SHORT;
                state_r   <= bpr_pkg::ST_ADV;
              end
            end
          end else if (is_down_r[bi]) begin
            is_down_r[bi]   <= 1'b0;
            hold_cons_r[bi] <= 1'b0;
            if (fired_r[bi]) begin
              fired_r[bi]   <= 1'b0;
              has_rep_r[bi] <= 1'b0;
            end else if (has_rep_r[bi]) begin
              has_rep_r[bi] <= 1'b0;
            end else if (!hold_cons_r[bi]) begin
              ev_kind_r <= (held_b >= {16'b0, lpms_r} && lpm_r[btn_r]) ?
                           bpr_pkg::KIND_LONG : bpr_pkg::KIND_SHORT;
              state_r   <= bpr_pkg::ST_ADV;
            end
          end
        end
        bpr_pkg::ST_BTN: begin
          ev_btn_r   <= cnt_r;
          ev_time_r  <= ms_r;
          state_r    <= bpr_pkg::ST_NEXT;
          if (is_down_r[ci] && !hold_cons_r[ci]) begin
            if (latched_r[ci]) begin
              if (held_c >= {16'b0, delay_r}) begin
                if (t_c >= {16'b0, ramp_r}) begin
                  rate_r  <= fast_r;
                  state_r <= bpr_pkg::ST_RATE_OK;
                end else begin
                  up_r      <= (fast_r >= slow_r);
                  div_q_r   <= {16'b0, {16'b0, diff} * {8'b0, t_c[15:0]}};
                  div_d_r   <= ramp_r;
                  div_rem_r <= '0;
                  div_cnt_r <= 6'(bpr_pkg::DIVN_W - 1);
                  ret_r     <= bpr_pkg::ST_RATE;
                  state_r   <= bpr_pkg::ST_DIV;
                end
              end
            end else if (!fired_r[ci] && lpm_r[cnt_r] && held_c >= {16'b0, lpms_r}) begin
              hold_cons_r[ci] <= 1'b1;
              ev_kind_r       <= bpr_pkg::KIND_LONG;
              ev_steps_r      <= 6'd1;
              ev_time_r       <= pst_r[ci] + {16'b0, lpms_r};
              state_r         <= bpr_pkg::ST_ADV;
            end
          end
        end
        bpr_pkg::ST_DIV: begin
          if (trial >= {1'b0, div_d_r}) begin
            div_rem_r <= 16'(trial - {1'b0, div_d_r});
            div_q_r   <= {div_q_r[38:0], 1'b1};
          end else begin
            div_rem_r <= trial[15:0];
            div_q_r   <= {div_q_r[38:0], 1'b0};
          end
          div_cnt_r <= div_cnt_r - 6'd1;
          if (div_cnt_r == 6'd0) begin
            state_r <= ret_r;
          end
        end
        bpr_pkg::ST_RATE: begin
          rate_r  <= up_r ? slow_r + div_q_r[7:0] : slow_r - div_q_r[7:0];
          state_r <= bpr_pkg::ST_RATE_OK;
        end
        bpr_pkg::ST_RATE_OK: begin
          if (rate_r == 8'd0) begin
            state_r <= bpr_pkg::ST_NEXT;
          end else begin
            anchor_r[ci] <= anc_new;
            div_q_r      <= {8'b0, elapsed} * {32'b0, rate_r};
            div_d_r      <= {6'b0, bpr_pkg::MS_PER_S};
            div_rem_r    <= '0;
            div_cnt_r    <= 6'(bpr_pkg::DIVN_W - 1);
            ret_r        <= bpr_pkg::ST_STEPS;
            state_r      <= bpr_pkg::ST_DIV;
          end
        end
        bpr_pkg::ST_STEPS: begin
          ev_kind_r <= bpr_pkg::KIND_REPEAT;
          if (div_q_r == '0) begin
            state_r <= bpr_pkg::ST_NEXT;
          end else if (div_q_r > {34'b0, cap}) begin
            ev_steps_r    <= cap;
            anchor_r[ci]  <= ms_r;
            has_rep_r[ci] <= 1'b1;
            state_r       <= bpr_pkg::ST_ADV;
          end else begin
            steps_r   <= div_q_r[5:0];
            div_q_r   <= {24'b0, {10'b0, div_q_r[5:0]} * {6'b0, bpr_pkg::MS_PER_S}};
            div_d_r   <= {8'b0, rate_r};
            div_rem_r <= '0;
            div_cnt_r <= 6'(bpr_pkg::DIVN_W - 1);
            ret_r     <= bpr_pkg::ST_ANCH;
            state_r   <= bpr_pkg::ST_DIV;
          end
        end
        bpr_pkg::ST_ANCH: begin
          anchor_r[ci]  <= anchor_r[ci] + div_q_r[31:0];
          has_rep_r[ci] <= 1'b1;
          ev_steps_r    <= steps_r;
          state_r       <= bpr_pkg::ST_ADV;
        end
        bpr_pkg::ST_ADV: begin
          if (!pend_v_r || out_free) begin
            if (pend_v_r) begin
              out_v_r     <= 1'b1;
              out_btn_r   <= pend_btn_r;
              out_kind_r  <= pend_kind_r;
              out_steps_r <= pend_steps_r;
              out_time_r  <= pend_time_r;
              out_last_r  <= 1'b0;
            end
            pend_v_r     <= 1'b1;
            pend_btn_r   <= ev_btn_r;
            pend_kind_r  <= ev_kind_r;
            pend_steps_r <= ev_steps_r;
            pend_time_r  <= ev_time_r;
            state_r <= (cmd_r == bpr_pkg::CMD_TICK) ? bpr_pkg::ST_NEXT : bpr_pkg::ST_FIN;
          end
        end
        bpr_pkg::ST_NEXT: begin
          if (cnt_r == LAST_BTN) begin
            state_r <= bpr_pkg::ST_FIN;
          end else begin
            cnt_r   <= cnt_r + 3'd1;
            state_r <= bpr_pkg::ST_BTN;
          end
        end
        bpr_pkg::ST_FIN: begin
          if (!pend_v_r) begin
            state_r <= bpr_pkg::ST_IDLE;
          end else if (out_free) begin
            out_v_r     <= 1'b1;
            out_btn_r   <= pend_btn_r;
            out_kind_r  <= pend_kind_r;
            out_steps_r <= pend_steps_r;
            out_time_r  <= pend_time_r;
            out_last_r  <= 1'b1;
            pend_v_r    <= 1'b0;
            state_r     <= bpr_pkg::ST_IDLE;
          end
        end
        default: state_r <= bpr_pkg::ST_IDLE;
      endcase
    end
  end

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench of the button press recognizer with a built-in event predictor.
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    logic [2:0]  btn;
    logic [1:0]  kind;
    logic [5:0]  steps;
    logic [31:0] stamp;
    logic        last;
  } press_event_t;

  localparam int NBTN = 7;
  localparam int SETTLE_CYCLES = 1200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [bpr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bpr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  bpr_in_if in_chan();
  bpr_out_if out_chan();

  button_press_recognizer dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  press_event_t pending_events[$];
  int mismatches = 0;
  bit calm = 1'b0;
  int hold_asked = 0;
  int hold_seen = 0;
  int hold_left = 0;
  logic [31:0] now_ms;

  logic [31:0] rep_mask, lp_mask, lp_ms, rep_delay, rep_ramp, slow_rate, fast_rate, max_steps;
  bit          is_down[NBTN], consumed[NBTN], repeated[NBTN], fired[NBTN], latched[NBTN];
  logic [31:0] start_ms[NBTN], anchor_ms[NBTN];

  function automatic void clear_presses();
    for (int i = 0; i < NBTN; i++) begin
      is_down[i] = 0; consumed[i] = 0; repeated[i] = 0; fired[i] = 0; latched[i] = 0;
      start_ms[i] = '0; anchor_ms[i] = '0;
    end
  endfunction

  function automatic void push_event(int b, bpr_pkg::kind_t k, logic [5:0] s,
                                     logic [31:0] t);
    press_event_t e;
    e.btn = 3'(b); e.kind = k; e.steps = s; e.stamp = t; e.last = 1'b0;
    pending_events.push_back(e);
  endfunction

  function automatic logic [31:0] ramp_rate(logic [31:0] held);
    logic [31:0] t;
    logic [63:0] d;
    if (held < rep_delay) return 0;
    t = held - rep_delay;
    if (t >= rep_ramp) return fast_rate;
    if (fast_rate >= slow_rate) begin
      d = (64'(fast_rate - slow_rate) * 64'(t)) / 64'(rep_ramp);
      return slow_rate + d[31:0];
    end
    d = (64'(slow_rate - fast_rate) * 64'(t)) / 64'(rep_ramp);
    return slow_rate - d[31:0];
  endfunction

  function automatic void predict_events(logic [1:0] cmd, logic [2:0] b, logic dn,
                                         logic [31:0] ms);
    int n;
    int base;
    logic [31:0] rate, cap;
    logic [63:0] steps;
    n = 0;
    base = pending_events.size();
    if (cmd == bpr_pkg::CMD_FORGET) begin
      clear_presses();
    end else if (cmd == bpr_pkg::CMD_EDGE && b < NBTN) begin
      if (dn) begin
        if (!is_down[b]) begin
          is_down[b] = 1; consumed[b] = 0; repeated[b] = 0; fired[b] = 0;
          anchor_ms[b] = ms; start_ms[b] = ms; latched[b] = rep_mask[b];
          if (!lp_mask[b]) begin
            fired[b] = 1;
            push_event(b, bpr_pkg::KIND_SHORT, 6'd1, ms);
          end
        end
      end else if (is_down[b]) begin
        is_down[b] = 0;
        if (fired[b]) begin
          fired[b] = 0; repeated[b] = 0;
        end else if (repeated[b]) begin
          repeated[b] = 0;
        end else if (!consumed[b]) begin
          push_event(b, (ms - start_ms[b] >= lp_ms && lp_mask[b]) ?
                     bpr_pkg::KIND_LONG : bpr_pkg::KIND_SHORT, 6'd1, ms);
        end
        consumed[b] = 0;
      end
    end else if (cmd == bpr_pkg::CMD_TICK) begin
      cap = (max_steps < 1) ? 1 : max_steps;
      for (int i = 0; i < NBTN; i++) begin
        if (!is_down[i] || consumed[i]) continue;
        if (latched[i]) begin
          rate = ramp_rate(ms - start_ms[i]);
          if (rate == 0) continue;
          if (!repeated[i]) anchor_ms[i] = start_ms[i] + rep_delay;
          steps = (64'(ms - anchor_ms[i]) * 64'(rate)) / 64'(bpr_pkg::MS_PER_S);
          if (steps == 0) continue;
          if (steps > 64'(cap)) begin
            steps = 64'(cap);
            anchor_ms[i] = ms;
          end else begin
            anchor_ms[i] = anchor_ms[i] +
                           32'((steps * 64'(bpr_pkg::MS_PER_S)) / 64'(rate));
          end
          repeated[i] = 1;
          push_event(i, bpr_pkg::KIND_REPEAT, steps[5:0], ms);
          continue;
        end
        if (fired[i] || !lp_mask[i]) continue;
        if (ms - start_ms[i] >= lp_ms) begin
          consumed[i] = 1;
          push_event(i, bpr_pkg::KIND_LONG, 6'd1, start_ms[i] + lp_ms);
        end
      end
    end
    n = pending_events.size() - base;
    if (n > 0) pending_events[pending_events.size() - 1].last = 1'b1;
  endfunction

  // Receiver: random stalls, plus a long hold-off counted here on request.
  always @(posedge clk) begin
    if (hold_asked != hold_seen) begin
      hold_seen <= hold_asked;
      hold_left <= 600;
      out_chan.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= calm || ($urandom_range(0, 99) >= 17);
    end
  end

  always @(posedge clk) begin
    press_event_t e;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected transaction: btn %0d kind %0d steps %0d time %0d last %0d",
                   out_chan.event_button, out_chan.event_kind, out_chan.repeat_steps,
                   out_chan.event_time, out_chan.last);
      end else begin
        e = pending_events.pop_front();
        if (out_chan.event_button !== e.btn || out_chan.event_kind !== e.kind ||
            out_chan.repeat_steps !== e.steps || out_chan.event_time !== e.stamp ||
            out_chan.last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected btn %0d kind %0d steps %0d time %0d last %0d, got btn %0d kind %0d steps %0d time %0d last %0d",
                     e.btn, e.kind, e.steps, e.stamp, e.last, out_chan.event_button,
                     out_chan.event_kind, out_chan.repeat_steps, out_chan.event_time,
                     out_chan.last);
        end
      end
    end
  end

  task automatic send_item(logic [1:0] cmd, logic [2:0] b, logic dn, logic [31:0] ms);
    int gap;
    gap = (!calm && $urandom_range(0, 99) < 17) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.command <= cmd;
    in_chan.button <= b;
    in_chan.key_down <= dn;
    in_chan.time_ms <= ms;
    do @(posedge clk); while (!in_chan.ready);
    predict_events(cmd, b, dn, ms);
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(bpr_pkg::reg_idx_t idx, logic [15:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bpr_pkg::REG_AUTO_REPEAT_MASK: begin
        rep_mask = 32'(val[6:0]);
        lp_mask = lp_mask & ~rep_mask;
      end
      bpr_pkg::REG_LONG_PRESS_MASK:  lp_mask = 32'(val[6:0]) & ~rep_mask;
      bpr_pkg::REG_LONG_PRESS_MS:    lp_ms = 32'(val);
      bpr_pkg::REG_REPEAT_DELAY_MS:  rep_delay = 32'(val);
      bpr_pkg::REG_REPEAT_RAMP_MS:   rep_ramp = 32'(val);
      bpr_pkg::REG_REPEAT_SLOW_RATE: slow_rate = 32'(val[7:0]);
      bpr_pkg::REG_REPEAT_FAST_RATE: fast_rate = 32'(val[7:0]);
      bpr_pkg::REG_REPEAT_MAX_STEPS: max_steps = 32'(val[5:0]);
      default: ;
    endcase
  endtask

  task automatic random_items(int count);
    int r;
    logic [2:0] b;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      b = 3'($urandom_range(0, 7));
      if (r < 35) begin
        now_ms += $urandom_range(0, 300);
        send_item(bpr_pkg::CMD_EDGE, b, ($urandom_range(0, 9) == 0) ? 1'($urandom) :
                  ((b < NBTN) ? !is_down[b] : 1'($urandom)), now_ms);
      end else if (r < 85) begin
        now_ms += ($urandom_range(0, 19) == 0) ? $urandom_range(0, 20000)
                                               : $urandom_range(0, 250);
        send_item(bpr_pkg::CMD_TICK, b, 1'($urandom), now_ms);
      end else if (r < 89) begin
        send_item(bpr_pkg::CMD_FORGET, b, 1'($urandom), $urandom);
      end else if (r < 92) begin
        send_item(2'd3, b, 1'($urandom), $urandom);
      end else begin
        now_ms = $urandom;
        send_item(bpr_pkg::CMD_EDGE, b, 1'($urandom), now_ms);
      end
    end
  endtask

  task automatic test_directed();
    write_reg(bpr_pkg::REG_AUTO_REPEAT_MASK, 16'h0003);
    write_reg(bpr_pkg::REG_LONG_PRESS_MASK, 16'h007F);
    now_ms = 32'hFFFF_FF00;
    send_item(bpr_pkg::CMD_EDGE, 3'd0, 1'b1, now_ms);
    send_item(bpr_pkg::CMD_EDGE, 3'd2, 1'b1, now_ms);
    send_item(bpr_pkg::CMD_EDGE, 3'd3, 1'b1, now_ms + 10);
    send_item(bpr_pkg::CMD_EDGE, 3'd3, 1'b1, now_ms + 50);
    send_item(bpr_pkg::CMD_EDGE, 3'd3, 1'b0, now_ms + 100);
    send_item(bpr_pkg::CMD_EDGE, 3'd4, 1'b0, now_ms + 100);
    send_item(bpr_pkg::CMD_EDGE, 3'd7, 1'b1, now_ms + 100);
    send_item(2'd3, 3'd1, 1'b1, now_ms + 100);
    send_item(bpr_pkg::CMD_TICK, 3'd0, 1'b0, now_ms + 450);
    send_item(bpr_pkg::CMD_TICK, 3'd0, 1'b0, now_ms + 700);
    send_item(bpr_pkg::CMD_TICK, 3'd0, 1'b0, now_ms + 2500);
    send_item(bpr_pkg::CMD_TICK, 3'd0, 1'b0, now_ms + 2540);
    send_item(bpr_pkg::CMD_EDGE, 3'd2, 1'b0, now_ms + 2600);
    send_item(bpr_pkg::CMD_EDGE, 3'd0, 1'b0, now_ms + 2600);
    send_item(bpr_pkg::CMD_EDGE, 3'd5, 1'b1, now_ms + 2600);
    send_item(bpr_pkg::CMD_EDGE, 3'd5, 1'b0, now_ms + 3200);
    send_item(bpr_pkg::CMD_EDGE, 3'd6, 1'b1, 32'h0);
    send_item(bpr_pkg::CMD_EDGE, 3'd1, 1'b1, 32'h0);
    send_item(bpr_pkg::CMD_FORGET, 3'd0, 1'b0, 32'hFFFF_FFFF);
    send_item(bpr_pkg::CMD_EDGE, 3'd6, 1'b0, 32'h1000);
    send_item(bpr_pkg::CMD_TICK, 3'd7, 1'b1, 32'hFFFF_FFFF);
    write_reg(bpr_pkg::REG_LONG_PRESS_MASK, 16'h0000);
    send_item(bpr_pkg::CMD_EDGE, 3'd4, 1'b1, 32'h5555_5555);
    send_item(bpr_pkg::CMD_EDGE, 3'd4, 1'b0, 32'hAAAA_AAAA);
  endtask

  task automatic test_config_phases();
    write_reg(bpr_pkg::REG_AUTO_REPEAT_MASK, 16'($urandom));
    write_reg(bpr_pkg::REG_LONG_PRESS_MASK, 16'hFFFF);
    write_reg(bpr_pkg::REG_LONG_PRESS_MS, 16'd0);
    write_reg(bpr_pkg::REG_REPEAT_DELAY_MS, 16'd0);
    write_reg(bpr_pkg::REG_REPEAT_RAMP_MS, 16'd1);
    write_reg(bpr_pkg::REG_REPEAT_SLOW_RATE, 16'hFF01);
    write_reg(bpr_pkg::REG_REPEAT_FAST_RATE, 16'h00FF);
    write_reg(bpr_pkg::REG_REPEAT_MAX_STEPS, 16'd63);
    random_items(20);
    write_reg(bpr_pkg::REG_AUTO_REPEAT_MASK, 16'h0055);
    write_reg(bpr_pkg::REG_LONG_PRESS_MASK, 16'h002A);
    write_reg(bpr_pkg::REG_LONG_PRESS_MS, 16'hFFFF);
    write_reg(bpr_pkg::REG_REPEAT_DELAY_MS, 16'hFFFF);
    write_reg(bpr_pkg::REG_REPEAT_RAMP_MS, 16'hFFFF);
    write_reg(bpr_pkg::REG_REPEAT_SLOW_RATE, 16'd200);
    write_reg(bpr_pkg::REG_REPEAT_FAST_RATE, 16'd7);
    write_reg(bpr_pkg::REG_REPEAT_MAX_STEPS, 16'd0);
    random_items(15);
    write_reg(bpr_pkg::REG_AUTO_REPEAT_MASK, 16'h007F);
    write_reg(bpr_pkg::REG_REPEAT_DELAY_MS, 16'd100);
    write_reg(bpr_pkg::REG_REPEAT_RAMP_MS, 16'd0);
    write_reg(bpr_pkg::REG_REPEAT_SLOW_RATE, 16'd0);
    write_reg(bpr_pkg::REG_REPEAT_FAST_RATE, 16'd0);
    write_reg(bpr_pkg::REG_REPEAT_MAX_STEPS, 16'hFFC2);
    random_items(15);
    write_reg(bpr_pkg::REG_REPEAT_SLOW_RATE, 16'd3);
    write_reg(bpr_pkg::REG_REPEAT_FAST_RATE, 16'd120);
    write_reg(bpr_pkg::REG_REPEAT_RAMP_MS, 16'd700);
    random_items(20);
  endtask

  task automatic test_backpressure();
    write_reg(bpr_pkg::REG_AUTO_REPEAT_MASK, 16'h0078);
    write_reg(bpr_pkg::REG_LONG_PRESS_MASK, 16'h0007);
    write_reg(bpr_pkg::REG_LONG_PRESS_MS, 16'd300);
    calm = 1'b1;
    hold_asked++;
    for (int i = 0; i < NBTN; i++) send_item(bpr_pkg::CMD_EDGE, 3'(i), 1'b1, now_ms);
    for (int k = 1; k <= 6; k++) send_item(bpr_pkg::CMD_TICK, 3'd0, 1'b0, now_ms + 400 * k);
    now_ms += 2400;
    calm = 1'b0;
  endtask

  task automatic test_random();
    write_reg(bpr_pkg::REG_AUTO_REPEAT_MASK, 16'($urandom));
    write_reg(bpr_pkg::REG_LONG_PRESS_MASK, 16'($urandom));
    write_reg(bpr_pkg::REG_LONG_PRESS_MS, 16'($urandom_range(0, 1500)));
    write_reg(bpr_pkg::REG_REPEAT_DELAY_MS, 16'($urandom_range(0, 800)));
    write_reg(bpr_pkg::REG_REPEAT_RAMP_MS, 16'($urandom_range(1, 3000)));
    write_reg(bpr_pkg::REG_REPEAT_SLOW_RATE, 16'($urandom_range(1, 60)));
    write_reg(bpr_pkg::REG_REPEAT_FAST_RATE, 16'($urandom_range(1, 255)));
    write_reg(bpr_pkg::REG_REPEAT_MAX_STEPS, 16'($urandom_range(1, 63)));
    calm = 1'b1;
    random_items(15);
    calm = 1'b0;
    random_items(20);
  endtask

  initial begin
    in_chan.valid = 1'b0;
    in_chan.command = bpr_pkg::CMD_EDGE;
    in_chan.button = '0;
    in_chan.key_down = 1'b0;
    in_chan.time_ms = '0;
    out_chan.ready = 1'b0;
    rep_mask = 0; lp_mask = 0; lp_ms = 500; rep_delay = 400; rep_ramp = 1000;
    slow_rate = 5; fast_rate = 30; max_steps = 4;
    clear_presses();
    now_ms = $urandom;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    random_items(10);
    test_directed();
    test_config_phases();
    test_backpressure();
    test_random();
    drain();
    if (mismatches == 0)
      $display("button_press_recognizer test passed");
    else
      $display("button_press_recognizer test failed");
    $finish;
  end

  initial begin
    #40ms;
    $display("button_press_recognizer test failed");
    $finish;
  end

endmodule
